// File: design/stsh_pkg.sv
// Package for the stereo transient shaper: widths, reset values, register
// indexes and the microcode table of the sequencer.
// No dependencies.
package stsh_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 24;
   localparam int AMOUNT_W   = 17;
   localparam int INDEX_W    = 3;
   localparam int CSR_DATA_W = (COEF_W > AMOUNT_W) ? COEF_W : AMOUNT_W;
   localparam int DATA_W     = ((2 * SAMPLE_W + 7) / 8) * 8;

   // gain excess k and boosted magnitude need two bits above the sample
   localparam int K_W    = SAMPLE_W + 2;
   localparam int MUL_W  = (COEF_W > K_W) ? COEF_W : K_W;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [COEF_W-1:0]   FAST_ATTACK_RST  = COEF_W'(345960);
   localparam logic [COEF_W-1:0]   FAST_RELEASE_RST = COEF_W'(34913);
   localparam logic [COEF_W-1:0]   SLOW_ATTACK_RST  = COEF_W'(17468);
   localparam logic [COEF_W-1:0]   SLOW_RELEASE_RST = COEF_W'(1747);
   localparam logic [AMOUNT_W-1:0] AMOUNT_RST       = '0;
   localparam logic [AMOUNT_W-1:0] AMOUNT_ONE       = AMOUNT_W'(65536);
   localparam logic [AMOUNT_W-1:0] AMOUNT_MIN       = AMOUNT_W'(66);

   localparam logic [PROD_W-1:0] STEP_RND = PROD_W'(1) << (COEF_W - 1);
   localparam logic [PROD_W-1:0] K_RND    = PROD_W'(1) << 15;
   localparam logic [PROD_W-1:0] INC_RND  = PROD_W'(1) << (SAMPLE_W - 2);
   localparam logic [K_W-1:0]    MAG_MAX  = K_W'(1) << (SAMPLE_W - 1);
   localparam logic [K_W-1:0]    POS_MAX  = MAG_MAX - K_W'(1);

   localparam logic [INDEX_W-1:0] REG_FAST_ATTACK  = INDEX_W'(0);
   localparam logic [INDEX_W-1:0] REG_FAST_RELEASE = INDEX_W'(1);
   localparam logic [INDEX_W-1:0] REG_SLOW_ATTACK  = INDEX_W'(2);
   localparam logic [INDEX_W-1:0] REG_SLOW_RELEASE = INDEX_W'(3);
   localparam logic [INDEX_W-1:0] REG_AMOUNT       = INDEX_W'(4);

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
   localparam logic [OP_W-1:0] OP_RECT     = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL_FAST = 4'd3;
   localparam logic [OP_W-1:0] OP_UPD_FAST = 4'd4;
   localparam logic [OP_W-1:0] OP_MUL_SLOW = 4'd5;
   localparam logic [OP_W-1:0] OP_UPD_SLOW = 4'd6;
   localparam logic [OP_W-1:0] OP_TRANS    = 4'd7;
   localparam logic [OP_W-1:0] OP_MUL_AMT  = 4'd8;
   localparam logic [OP_W-1:0] OP_ROUND_K  = 4'd9;
   localparam logic [OP_W-1:0] OP_MUL_MAG  = 4'd10;
   localparam logic [OP_W-1:0] OP_STORE    = 4'd11;
   localparam logic [OP_W-1:0] OP_PUSH     = 4'd12;
   localparam logic [OP_W-1:0] OP_PASS     = 4'd13;

   // hold conditions: the step repeats and its operation is suppressed
   localparam logic [1:0] WAIT_NONE = 2'd0;
   localparam logic [1:0] WAIT_REQ  = 2'd1;
   localparam logic [1:0] WAIT_OUT  = 2'd2;

   // jump conditions: taken jumps go to the target, else advance
   localparam logic [1:0] JMP_NONE   = 2'd0;
   localparam logic [1:0] JMP_ALWAYS = 2'd1;
   localparam logic [1:0] JMP_BYPASS = 2'd2;
   localparam logic [1:0] JMP_LEFT   = 2'd3;

   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
   localparam logic [PC_W-1:0] PC_CHAN = PC_W'(1);
   localparam logic [PC_W-1:0] PC_PUSH = PC_W'(11);
   localparam logic [PC_W-1:0] PC_PASS = PC_W'(12);

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      wait_cond;
      logic [1:0]      jump_cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         PC_IDLE:    w = '{OP_ACCEPT,   WAIT_REQ,  JMP_BYPASS, PC_PASS};
         PC_CHAN:    w = '{OP_RECT,     WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(2):   w = '{OP_MUL_FAST, WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(3):   w = '{OP_UPD_FAST, WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(4):   w = '{OP_MUL_SLOW, WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(5):   w = '{OP_UPD_SLOW, WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(6):   w = '{OP_TRANS,    WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(7):   w = '{OP_MUL_AMT,  WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(8):   w = '{OP_ROUND_K,  WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(9):   w = '{OP_MUL_MAG,  WAIT_NONE, JMP_NONE,   PC_IDLE};
         PC_W'(10):  w = '{OP_STORE,    WAIT_NONE, JMP_LEFT,   PC_CHAN};
         PC_PUSH:    w = '{OP_PUSH,     WAIT_OUT,  JMP_ALWAYS, PC_IDLE};
         PC_PASS:    w = '{OP_PASS,     WAIT_NONE, JMP_ALWAYS, PC_PUSH};
         default:    w = '{OP_NOP,      WAIT_NONE, JMP_ALWAYS, PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: design/stereo_transient_shaper_top.sv
// Stereo transient shaper: microcoded sequencer over one shared multiplier,
// with fast and slow peak envelopes per channel.
// Depends on stsh_pkg (widths, constants, microcode table).
//
//  channel   direction  handshake               payload
//  req_      in         req_tvalid/req_tready   req_tdata: left_in, right_in
//  rsp_      out        rsp_tvalid/rsp_tready   rsp_tdata: left_out, right_out
//  csr_      in         csr_wr_en               csr_index, csr_wdata
//
// A shaped word occupies the sequencer for one accept step, ten steps per
// channel through the shared multiplier (two envelope updates, amount
// scaling, gain), and one push step, which loads the output register. In
// bypass a word takes an accept step, a pass step and a push step. The next
// word can be accepted the cycle after the push.
// Reset (synchronous, active high) clears the envelopes, loads the register
// defaults and returns the sequencer to its accept step. A stalled output
// holds the sequencer at its push step; a new word is already taken while the
// previous result waits in the output register.
module stereo_transient_shaper_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [stsh_pkg::DATA_W-1:0]          req_tdata,   // left_in, right_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [stsh_pkg::DATA_W-1:0]          rsp_tdata,   // left_out, right_out
   input  logic                                 csr_wr_en,
   input  logic [stsh_pkg::INDEX_W-1:0]         csr_index,
   input  logic [stsh_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import stsh_pkg::*;

   // configuration registers
   logic [COEF_W-1:0]   fast_att_ff, fast_rel_ff, slow_att_ff, slow_rel_ff;
   logic [AMOUNT_W-1:0] amount_ff;
   logic [AMOUNT_W-1:0] amount_eff;
   logic                bypass;

   // sequencer
   ctrl_word_type   ctrl;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            wait_hit, jump_hit, fire;

   // datapath state
   logic [SAMPLE_W-1:0] fast_env_ff [2];
   logic [SAMPLE_W-1:0] slow_env_ff [2];
   logic [SAMPLE_W-1:0] fast_env_in [2];
   logic [SAMPLE_W-1:0] slow_env_in [2];
   logic                chan_ff, chan_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath payload
   logic [SAMPLE_W-1:0] in_left_ff, in_left_in, in_right_ff, in_right_in;
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic                neg_ff, neg_in, up_ff, up_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [K_W-1:0]      t3_ff, t3_in, k_ff, k_in;
   logic [SAMPLE_W-1:0] res_ff [2];
   logic [SAMPLE_W-1:0] res_in [2];
   logic [SAMPLE_W-1:0] out_left_ff, out_left_in, out_right_ff, out_right_in;

   // combinational helpers
   logic [SAMPLE_W-1:0] x_cur, mag_calc, env_cur, diff, step, env_upd, trans;
   logic [COEF_W-1:0]   coef;
   logic                use_slow, up_calc, out_busy;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]   prod_calc, step_sum, k_sum, inc_sum;
   logic [K_W-1:0]      inc, y, y_lim;
   logic [SAMPLE_W-1:0] y_out;

   // register file: the user must write only while idle; the block itself does not guard writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_att_ff <= FAST_ATTACK_RST;
         fast_rel_ff <= FAST_RELEASE_RST;
         slow_att_ff <= SLOW_ATTACK_RST;
         slow_rel_ff <= SLOW_RELEASE_RST;
         amount_ff   <= AMOUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FAST_ATTACK:  fast_att_ff <= csr_wdata[COEF_W-1:0];
            REG_FAST_RELEASE: fast_rel_ff <= csr_wdata[COEF_W-1:0];
            REG_SLOW_ATTACK:  slow_att_ff <= csr_wdata[COEF_W-1:0];
            REG_SLOW_RELEASE: slow_rel_ff <= csr_wdata[COEF_W-1:0];
            REG_AMOUNT:       amount_ff   <= csr_wdata[AMOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // amounts above one act as one; small amounts bypass the shaper
   assign amount_eff = (amount_ff > AMOUNT_ONE) ? AMOUNT_ONE : amount_ff;
   assign bypass     = (amount_ff < AMOUNT_MIN);

   // sequencer: fetch, hold, jump or advance
   assign ctrl     = ucode_rom(pc_ff);
   assign out_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      case (ctrl.wait_cond)
         WAIT_REQ: wait_hit = !req_tvalid;
         WAIT_OUT: wait_hit = out_busy;
         default:  wait_hit = 1'b0;
      endcase
      case (ctrl.jump_cond)
         JMP_ALWAYS: jump_hit = 1'b1;
         JMP_BYPASS: jump_hit = bypass;
         JMP_LEFT:   jump_hit = !chan_ff;
         default:    jump_hit = 1'b0;
      endcase
   end

   assign fire  = !wait_hit;
   assign pc_in = wait_hit ? pc_ff : (jump_hit ? ctrl.target : pc_ff + PC_W'(1));

   assign req_tready = (ctrl.op == OP_ACCEPT);

   // shared arithmetic
   always_comb begin
      x_cur    = chan_ff ? in_right_ff : in_left_ff;
      mag_calc = x_cur[SAMPLE_W-1] ? (~x_cur + SAMPLE_W'(1)) : x_cur;

      use_slow = (ctrl.op == OP_MUL_SLOW) || (ctrl.op == OP_UPD_SLOW);
      env_cur  = use_slow ? slow_env_ff[chan_ff] : fast_env_ff[chan_ff];
      up_calc  = (mag_ff > env_cur);
      diff     = up_calc ? (mag_ff - env_cur) : (env_cur - mag_ff);
      if (use_slow) begin
         coef = up_calc ? slow_att_ff : slow_rel_ff;
      end else begin
         coef = up_calc ? fast_att_ff : fast_rel_ff;
      end

      case (ctrl.op)
         OP_MUL_FAST, OP_MUL_SLOW: begin
            mul_a = MUL_W'(diff);
            mul_b = MUL_W'(coef);
         end
         OP_MUL_AMT: begin
            mul_a = MUL_W'(t3_ff);
            mul_b = MUL_W'(amount_eff);
         end
         OP_MUL_MAG: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = MUL_W'(k_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_calc = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

      // envelope step rounds half up; never passes the magnitude
      step_sum = prod_ff + STEP_RND;
      step     = step_sum[COEF_W+SAMPLE_W-1:COEF_W];
      env_upd  = up_ff ? (env_cur + step) : (env_cur - step);

      trans = (fast_env_ff[chan_ff] > slow_env_ff[chan_ff]) ?
              (fast_env_ff[chan_ff] - slow_env_ff[chan_ff]) : '0;

      k_sum   = prod_ff + K_RND;
      inc_sum = prod_ff + INC_RND;
      inc     = inc_sum[SAMPLE_W+K_W-2:SAMPLE_W-1];
      y       = {2'b00, mag_ff} + inc;

      // saturate: negative side reaches one more step
      if (neg_ff) begin
         y_lim = (y > MAG_MAX) ? MAG_MAX : y;
         y_out = ~y_lim[SAMPLE_W-1:0] + SAMPLE_W'(1);
      end else begin
         y_lim = (y > POS_MAX) ? POS_MAX : y;
         y_out = y_lim[SAMPLE_W-1:0];
      end
   end

   // operation decode
   always_comb begin
      fast_env_in  = fast_env_ff;
      slow_env_in  = slow_env_ff;
      chan_in      = chan_ff;
      in_left_in   = in_left_ff;
      in_right_in  = in_right_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      up_in        = up_ff;
      prod_in      = prod_ff;
      t3_in        = t3_ff;
      k_in         = k_ff;
      res_in       = res_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (fire) begin
         case (ctrl.op)
            OP_ACCEPT: begin
               in_left_in  = req_tdata[SAMPLE_W-1:0];
               in_right_in = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
               chan_in     = 1'b0;
            end
            OP_RECT: begin
               mag_in = mag_calc;
               neg_in = x_cur[SAMPLE_W-1];
            end
            OP_MUL_FAST, OP_MUL_SLOW, OP_MUL_AMT, OP_MUL_MAG: begin
               prod_in = prod_calc;
               up_in   = up_calc;
            end
            OP_UPD_FAST: fast_env_in[chan_ff] = env_upd;
            OP_UPD_SLOW: slow_env_in[chan_ff] = env_upd;
            OP_TRANS:    t3_in = {2'b00, trans} + {1'b0, trans, 1'b0};
            OP_ROUND_K:  k_in  = k_sum[16+K_W-1:16];
            OP_STORE: begin
               res_in[chan_ff] = y_out;
               chan_in         = !chan_ff;
            end
            OP_PASS: begin
               res_in[0] = in_left_ff;
               res_in[1] = in_right_ff;
            end
            OP_PUSH: begin
               out_left_in  = res_ff[0];
               out_right_in = res_ff[1];
               rsp_valid_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         chan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fast_env_ff  <= '{default: '0};
         slow_env_ff  <= '{default: '0};
      end else begin
         pc_ff        <= pc_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
         fast_env_ff  <= fast_env_in;
         slow_env_ff  <= slow_env_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      in_left_ff   <= in_left_in;
      in_right_ff  <= in_right_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      up_ff        <= up_in;
      prod_ff      <= prod_in;
      t3_ff        <= t3_in;
      k_ff         <= k_in;
      res_ff       <= res_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({out_right_ff, out_left_ff});

endmodule

// File: tb/tb_stereo_transient_shaper_top.sv
// Self-checking testbench for stereo_transient_shaper_top: directed and random stereo
// words against a bit-exact envelope follower predictor, under idle and stall phases.
// Depends on stsh_pkg and the stereo_transient_shaper_top RTL.
module tb_stereo_transient_shaper_top;
   import stsh_pkg::*;

   // generous cycle budget for the whole run
   localparam int RUN_LIMIT  = 400000;
   // cycles to watch after the last word, well past the shaping latency
   localparam int SETTLE_CYC = 60;

   localparam logic [SAMPLE_W-1:0] S_MAX = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic [SAMPLE_W-1:0] S_MIN = SAMPLE_W'(1 << (SAMPLE_W - 1));
   localparam logic [SAMPLE_W-1:0] S_NEG_ONE = '1;
   localparam logic [CSR_DATA_W-1:0] CSR_ALL_ONES = '1;

   // one stereo word: left in the low bits, right above it
   typedef struct packed {
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] left;
   } stereo_word_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DATA_W-1:0]       req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [DATA_W-1:0]       rsp_tdata;
   logic                    csr_wr_en  = 1'b0;
   logic [INDEX_W-1:0]      csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // shadow copy of the control registers, loaded with the reset defaults
   logic [COEF_W-1:0]   fast_att_q = FAST_ATTACK_RST;
   logic [COEF_W-1:0]   fast_rel_q = FAST_RELEASE_RST;
   logic [COEF_W-1:0]   slow_att_q = SLOW_ATTACK_RST;
   logic [COEF_W-1:0]   slow_rel_q = SLOW_RELEASE_RST;
   logic [AMOUNT_W-1:0] amount_q   = AMOUNT_RST;

   // shadow envelopes, index 0 left and 1 right, cleared like the block's
   logic [SAMPLE_W-1:0] fast_env [2] = '{default: '0};
   logic [SAMPLE_W-1:0] slow_env [2] = '{default: '0};

   // shaped words still owed by the block, oldest first
   stereo_word_type shaped_fifo [$];

   int     error_count = 0;
   int     idle_pct    = 0;
   int     stall_pct   = 0;
   longint cycle_count = 0;

   stereo_transient_shaper_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Move an envelope toward the magnitude by a rounded fraction of the gap;
   // attack when the magnitude is above the envelope, release otherwise.
   function automatic logic [SAMPLE_W-1:0] follow_env(input logic [SAMPLE_W-1:0] env,
                                                      input logic [SAMPLE_W-1:0] mag,
                                                      input logic [COEF_W-1:0]   att,
                                                      input logic [COEF_W-1:0]   rel);
      logic [63:0] step;
      if (mag > env) begin
         step = (64'(att) * 64'(mag - env) + (64'd1 << (COEF_W - 1))) >> COEF_W;
         return env + SAMPLE_W'(step);
      end
      step = (64'(rel) * 64'(env - mag) + (64'd1 << (COEF_W - 1))) >> COEF_W;
      return env - SAMPLE_W'(step);
   endfunction

   // Update one channel's envelopes and boost its sample by the transient level.
   function automatic logic [SAMPLE_W-1:0] shape_sample(input int ch,
                                                        input logic [SAMPLE_W-1:0] x,
                                                        input logic [63:0] amt);
      logic                neg;
      logic [SAMPLE_W-1:0] mag;
      logic [63:0]         trans;
      logic [63:0]         k;
      logic [63:0]         y;
      neg = x[SAMPLE_W-1];
      // the most negative sample rectifies to 2^(SAMPLE_W-1), which still fits
      mag = neg ? (SAMPLE_W'(0) - x) : x;
      fast_env[ch] = follow_env(fast_env[ch], mag, fast_att_q, fast_rel_q);
      slow_env[ch] = follow_env(slow_env[ch], mag, slow_att_q, slow_rel_q);
      trans = (fast_env[ch] > slow_env[ch]) ? 64'(fast_env[ch] - slow_env[ch]) : 64'd0;
      k = (trans * 64'd3 * amt + 64'd32768) >> 16;
      y = 64'(mag) + ((64'(mag) * k + (64'd1 << (SAMPLE_W - 2))) >> (SAMPLE_W - 1));
      if (neg) begin
         if (y > (64'd1 << (SAMPLE_W - 1)))
            y = 64'd1 << (SAMPLE_W - 1);
         return SAMPLE_W'(64'd0 - y);
      end
      if (y > (64'd1 << (SAMPLE_W - 1)) - 64'd1)
         y = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
      return SAMPLE_W'(y);
   endfunction

   // Expected output word for one accepted input word.
   function automatic stereo_word_type predict_word(input stereo_word_type w);
      stereo_word_type shaped;
      logic [63:0]     amt;
      // amounts above one saturate at one
      amt = (amount_q > AMOUNT_ONE) ? 64'(AMOUNT_ONE) : 64'(amount_q);
      // below the threshold the block is bypassed and the envelopes hold
      if (amt < 64'(AMOUNT_MIN))
         return w;
      shaped.left  = shape_sample(0, w.left, amt);
      shaped.right = shape_sample(1, w.right, amt);
      return shaped;
   endfunction

   // ---------------------------------------------------------------------
   // Output side: random back-pressure and the result checker
   // ---------------------------------------------------------------------

   // Drop rsp_tready with a chance of stall_pct percent, drawn anew on each falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare every accepted output word with the oldest prediction.
   always @(posedge clock) begin : check_result
      stereo_word_type got;
      stereo_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (shaped_fifo.size() == 0) begin
            $display("%0t: unexpected word, left %0d right %0d", $time,
                     $signed(got.left), $signed(got.right));
            error_count++;
         end else begin
            want = shaped_fifo.pop_front();
            if (got.left !== want.left) begin
               $display("%0t: left_out expected %0d got %0d", $time,
                        $signed(want.left), $signed(got.left));
               error_count++;
            end
            if (got.right !== want.right) begin
               $display("%0t: right_out expected %0d got %0d", $time,
                        $signed(want.right), $signed(got.right));
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run as a failure once the cycle budget is spent.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("stereo_transient_shaper_top regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Input side helpers; the tasks among them start and end on a falling edge
   // ---------------------------------------------------------------------

   // Offer one stereo word, after an optional random idle gap, and hold it
   // until accepted. Predict at acceptance so the envelope order matches.
   task automatic send_word(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
      stereo_word_type w;
      w.left  = left;
      w.right = right;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      shaped_fifo.push_back(predict_word(w));
      @(negedge clock);
   endtask

   // Hold off the sender until every owed word has come out; always waits for a
   // falling edge first so back-to-back calls never drive req_tvalid twice at once.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (shaped_fifo.size() != 0)
         @(negedge clock);
   endtask

   // Write one control register and mirror it in the shadow copy. Call only
   // while the block is idle.
   task automatic csr_write(input logic [INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_FAST_ATTACK:  fast_att_q = value[COEF_W-1:0];
         REG_FAST_RELEASE: fast_rel_q = value[COEF_W-1:0];
         REG_SLOW_ATTACK:  slow_att_q = value[COEF_W-1:0];
         REG_SLOW_RELEASE: slow_rel_q = value[COEF_W-1:0];
         REG_AMOUNT:       amount_q   = value[AMOUNT_W-1:0];
         default: ;  // unmapped index: the block ignores it
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] extreme_sample();
      case ($urandom_range(4))
         0:       return S_MIN;
         1:       return S_MAX;
         2:       return '0;
         3:       return S_NEG_ONE;
         default: return SAMPLE_W'(1);
      endcase
   endfunction

   // Random sample whose magnitude sits between half the level and the level.
   function automatic logic [SAMPLE_W-1:0] burst_sample(input int unsigned level);
      int unsigned mag;
      mag = $urandom_range(level, level >> 1);
      if ($urandom_range(1) == 1)
         return SAMPLE_W'(32'd0 - mag);
      if (mag > 32'(S_MAX))
         mag = 32'(S_MAX);
      return SAMPLE_W'(mag);
   endfunction

   // Audio-like traffic: mostly decaying bursts with sharp onsets, which is
   // what drives the fast and slow envelopes apart, plus full-range noise and
   // extremes.
   task automatic play_audio(input int count);
      int unsigned         level_l;
      int unsigned         level_r;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      int                  mode;
      level_l = 0;
      level_r = 0;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(9);
         if (mode == 0) begin
            left  = SAMPLE_W'($urandom);
            right = SAMPLE_W'($urandom);
         end else if (mode == 1) begin
            left  = extreme_sample();
            right = extreme_sample();
         end else begin
            // fire a new onset now and then, otherwise decay by one eighth
            if ($urandom_range(11) == 0)
               level_l = $urandom_range(32'(S_MIN), 65536);
            else
               level_l = level_l - (level_l >> 3);
            if ($urandom_range(11) == 0)
               level_r = $urandom_range(32'(S_MIN), 65536);
            else
               level_r = level_r - (level_r >> 3);
            left  = burst_sample(level_l);
            right = burst_sample(level_r);
         end
         send_word(left, right);
      end
   endtask

   // Load one of several register settings, the extremes among them.
   task automatic load_setting(input int sel);
      case (sel)
         0: begin
            csr_write(REG_FAST_ATTACK,  CSR_DATA_W'(FAST_ATTACK_RST));
            csr_write(REG_FAST_RELEASE, CSR_DATA_W'(FAST_RELEASE_RST));
            csr_write(REG_SLOW_ATTACK,  CSR_DATA_W'(SLOW_ATTACK_RST));
            csr_write(REG_SLOW_RELEASE, CSR_DATA_W'(SLOW_RELEASE_RST));
            csr_write(REG_AMOUNT,       CSR_DATA_W'(AMOUNT_ONE));
         end
         1: begin
            csr_write(REG_FAST_ATTACK,  CSR_DATA_W'($urandom));
            csr_write(REG_FAST_RELEASE, CSR_DATA_W'($urandom));
            csr_write(REG_SLOW_ATTACK,  CSR_DATA_W'($urandom));
            csr_write(REG_SLOW_RELEASE, CSR_DATA_W'($urandom));
            csr_write(REG_AMOUNT,       CSR_DATA_W'($urandom_range(65536, 66)));
         end
         2: begin
            // everything at full scale; the amount masks to above one
            csr_write(REG_FAST_ATTACK,  CSR_ALL_ONES);
            csr_write(REG_FAST_RELEASE, CSR_ALL_ONES);
            csr_write(REG_SLOW_ATTACK,  CSR_ALL_ONES);
            csr_write(REG_SLOW_RELEASE, CSR_ALL_ONES);
            csr_write(REG_AMOUNT,       CSR_ALL_ONES);
         end
         3: begin
            // instant fast envelope, frozen slow envelope: maximum transient
            csr_write(REG_FAST_ATTACK,  CSR_ALL_ONES);
            csr_write(REG_FAST_RELEASE, CSR_ALL_ONES);
            csr_write(REG_SLOW_ATTACK,  '0);
            csr_write(REG_SLOW_RELEASE, '0);
            csr_write(REG_AMOUNT,       CSR_DATA_W'($urandom_range(65536, 66)));
         end
         4: begin
            csr_write(REG_FAST_ATTACK,  '0);
            csr_write(REG_FAST_RELEASE, '0);
            csr_write(REG_SLOW_ATTACK,  '0);
            csr_write(REG_SLOW_RELEASE, '0);
            csr_write(REG_AMOUNT,       CSR_DATA_W'($urandom_range(65536, 66)));
         end
         default: begin
            // random amount over the whole port, often near the bypass threshold
            csr_write(REG_FAST_ATTACK,  CSR_DATA_W'($urandom));
            csr_write(REG_FAST_RELEASE, CSR_DATA_W'($urandom));
            csr_write(REG_SLOW_ATTACK,  CSR_DATA_W'($urandom));
            csr_write(REG_SLOW_RELEASE, CSR_DATA_W'($urandom));
            if ($urandom_range(1) == 1)
               csr_write(REG_AMOUNT, CSR_DATA_W'($urandom_range(200, 0)));
            else
               csr_write(REG_AMOUNT, CSR_DATA_W'($urandom));
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Out of reset the amount is zero: words pass through untouched.
   task automatic test_reset_bypass();
      send_word(S_MIN, S_MAX);
      send_word(S_MAX, S_MIN);
      send_word('0, S_NEG_ONE);
      send_word(SAMPLE_W'(24'h555555), SAMPLE_W'(24'hAAAAAA));
      drain_results();
   endtask

   // Full amount: onsets, decays, both rails, saturation and zero coefficients.
   task automatic test_shaping_extremes();
      csr_write(REG_AMOUNT, CSR_DATA_W'(AMOUNT_ONE));
      send_word(S_MAX, S_MIN);
      send_word(S_MAX, S_MIN);
      send_word('0, '0);
      send_word(SAMPLE_W'(1), S_NEG_ONE);
      drain_results();
      // instant fast attack over a frozen slow envelope pushes the gain to 4x
      csr_write(REG_FAST_ATTACK, CSR_ALL_ONES);
      csr_write(REG_SLOW_ATTACK, '0);
      send_word(S_MAX, S_MIN);
      send_word(SAMPLE_W'(24'h400000), SAMPLE_W'(24'hC00000));
      send_word(S_MIN, S_MAX);
      drain_results();
      // zero fast release holds the fast envelope; full slow release empties the slow one
      csr_write(REG_FAST_RELEASE, '0);
      csr_write(REG_SLOW_RELEASE, CSR_ALL_ONES);
      send_word('0, '0);
      send_word(SAMPLE_W'(24'h100000), SAMPLE_W'(24'hF00000));
      drain_results();
   endtask

   // Bypass threshold, amount above one, masking of high bits, unmapped indexes.
   task automatic test_amount_limits();
      csr_write(REG_AMOUNT, CSR_DATA_W'(AMOUNT_MIN) - CSR_DATA_W'(1));
      send_word(S_MAX, S_MIN);
      drain_results();
      csr_write(REG_AMOUNT, CSR_DATA_W'(AMOUNT_MIN));
      send_word(S_MAX, S_MIN);
      drain_results();
      csr_write(REG_AMOUNT, CSR_DATA_W'(24'h01FFFF));
      send_word(SAMPLE_W'(24'h200000), SAMPLE_W'(24'hE00000));
      drain_results();
      // bits above the amount width drop, leaving a bypass value
      csr_write(REG_AMOUNT, CSR_DATA_W'(24'hFE0028));
      send_word(SAMPLE_W'(24'h123456), SAMPLE_W'(24'hEDCBA9));
      drain_results();
      // writes to unmapped indexes must leave every register alone
      csr_write(REG_AMOUNT, CSR_DATA_W'(AMOUNT_ONE));
      for (int idx = int'(REG_AMOUNT) + 1; idx < (1 << INDEX_W); idx++)
         csr_write(INDEX_W'(idx), '0);
      send_word(S_MIN, S_MAX);
      send_word(SAMPLE_W'(24'h0F0F0F), SAMPLE_W'(24'hF0F0F0));
      drain_results();
   endtask

   // One idling phase: four segments, each under its own register setting.
   // Draining before each reload also makes the sender wait for all results.
   task automatic test_random_traffic(input int send_idle, input int recv_stall, input int phase);
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      for (int seg = 0; seg < 4; seg++) begin
         drain_results();
         load_setting((phase * 4 + seg) % 6);
         play_audio(44);
      end
      drain_results();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      // hold reset, then release it on a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_bypass();
      test_shaping_extremes();
      test_amount_limits();

      test_random_traffic(0, 0, 0);    // no idling
      test_random_traffic(73, 0, 1);   // sender mostly idle
      test_random_traffic(0, 73, 2);   // receiver mostly stalled
      test_random_traffic(6, 6, 3);    // light idling on both sides

      // watch for stray words after the last expected one
      drain_results();
      repeat (SETTLE_CYC) @(negedge clock);

      if (error_count == 0 && shaped_fifo.size() == 0)
         $display("stereo_transient_shaper_top regression: pass");
      else
         $display("stereo_transient_shaper_top regression: fail");
      $finish;
   end

endmodule
